/* sv/quaternion_alu_assert.svh */
// Assertion macros shared by the quaternion ALU RTL.
`ifndef QUATERNION_ALU_ASSERT_SVH
`define QUATERNION_ALU_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QALU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define QALU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/qalu_pkg.sv */
// Types and constants for the quaternion ALU.
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

   localparam int FRAC   = 14;           // Q1.14 fraction bits
   localparam int ROT_SH = 2 * FRAC;     // rotate sums are Q.42
   localparam int DW     = 16;           // component width
   localparam int PW     = 2 * DW;       // 16x16 product
   localparam int SW     = PW + 2;       // sum of four products
   localparam int RPW    = SW + DW;      // stage-two sum times component
   localparam int RSW    = RPW + 2;      // sum of four rotate products
   localparam int RNDW   = RSW - ROT_SH; // rounded value before clipping

   typedef enum logic [1:0] {
      OP_MUL   = 2'd0,
      OP_CONJ  = 2'd1,
      OP_ROT   = 2'd2,
      OP_SCALE = 2'd3
   } op_type;

   typedef logic signed [DW-1:0] fix_type;

   localparam fix_type FIX_MAX = 16'sh7FFF;
   localparam fix_type FIX_MIN = 16'sh8000;

   typedef struct packed {
      op_type  opcode;
      fix_type a_w;
      fix_type a_x;
      fix_type a_y;
      fix_type a_z;
      fix_type b_w;
      fix_type b_x;
      fix_type b_y;
      fix_type b_z;
      fix_type scale;
   } req_type;

   typedef struct packed {
      fix_type r_w;
      fix_type r_x;
      fix_type r_y;
      fix_type r_z;
      logic    saturated;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/quaternion_alu.sv */
// Quaternion ALU top level: five-stage elastic pipeline.
//
// Usage:
//  - req channel (req_valid/req_ready/req_item) takes one item per clock while
//    req_ready is high: opcode, quaternions A and B and a scale factor, all Q1.14.
//  - rsp channel (rsp_valid/rsp_ready/rsp_item) returns exactly one
//    result per item, in order: r_w..r_z plus a saturated flag.
//  - Opcodes: multiply A*B, conjugate A, rotate B's vector by A, scale A.
//  - Depth: five register stages; an accepted item is offered as a
//    result once it reaches the output register.
//  - Throughput: one item per clock while rsp_ready stays high, set by the
//    stage registers; every stage holds one item and moves whenever the next one frees up.
//  - Stages: 16x16 products | Q.28 sums | rotate products | round |
//    saturate into the output register.
//  - Receiver stall: an item holds in its stage; bubbles ahead of it are
//    squeezed out, and req_ready drops only when all five stages are full.
//  - Reset (synchronous, active high) empties the pipeline; no result is
//    offered until new items arrive.
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_alu_assert.svh"

module quaternion_alu (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire qalu_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output qalu_pkg::rsp_type      rsp_item
);
   import qalu_pkg::*;

   // Stage enables: a stage loads when empty or when its item moves on.
   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // Stage 1: full outer product A x B (B's scalar replaced by scale for OP_SCALE)
   op_type                 op1_ff;
   fix_type                a1_ff    [4];
   logic signed [PW-1:0]   prod1_ff [4][4];
   logic signed [PW-1:0]   prod1_in [4][4];
   fix_type                a_in     [4];
   fix_type                b_in     [4];

   // Stage 2: Q.28 sums (result for mul/scale/conj, P = A*(0,v) for rotate)
   op_type                 op2_ff;
   fix_type                a2_ff [4];
   logic signed [SW-1:0]   q2_ff [4];
   logic signed [SW-1:0]   q2_in [4];

   // Stage 3: rotate products P * conj(A); other ops pass their sums
   op_type                 op3_ff;
   logic signed [SW-1:0]   q3_ff [4];
   logic signed [RPW-1:0]  m3_ff [12];
   logic signed [RPW-1:0]  m3_in [12];

   // Stage 4: rounded values
   op_type                 op4_ff;
   logic signed [RNDW-1:0] rnd4_ff [4];
   logic signed [RNDW-1:0] rnd4_in [4];
   logic signed [RSW-1:0]  rot_sum [3];
   logic signed [RSW-1:0]  lin_sum [4];

   // Stage 5: saturated output register
   rsp_type                rsp5_ff;
   rsp_type                rsp5_in;

   function automatic fix_type clip(input logic signed [RNDW-1:0] v, output logic hit);
      fix_type r;
      begin
         hit = 1'b0;
         r   = v[DW-1:0];
         if (v > RNDW'(FIX_MAX)) begin
            r   = FIX_MAX;
            hit = 1'b1;
         end else if (v < RNDW'(FIX_MIN)) begin
            r   = FIX_MIN;
            hit = 1'b1;
         end
         return r;
      end
   endfunction

   assign en5       = !v5_ff || rsp_ready;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v5_ff;
   assign rsp_item  = rsp5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // ---------------- stage 1 ----------------
   always_comb begin
      a_in[0] = req_item.a_w;
      a_in[1] = req_item.a_x;
      a_in[2] = req_item.a_y;
      a_in[3] = req_item.a_z;
      b_in[0] = (req_item.opcode == OP_SCALE) ? req_item.scale : req_item.b_w;
      b_in[1] = req_item.b_x;
      b_in[2] = req_item.b_y;
      b_in[3] = req_item.b_z;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod1_in[i][j] = PW'(a_in[i]) * PW'(b_in[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff   <= req_item.opcode;
         a1_ff    <= a_in;
         prod1_ff <= prod1_in;
      end
   end

   // ---------------- stage 2 ----------------
   // Index 0..3 = w, x, y, z; prod1_ff[i][j] = a_i * b_j.
   always_comb begin
      logic signed [SW-1:0] t [4];
      t[0] = -(SW'(prod1_ff[1][1]) + SW'(prod1_ff[2][2]) + SW'(prod1_ff[3][3]));
      t[1] = SW'(prod1_ff[0][1]) + SW'(prod1_ff[2][3]) - SW'(prod1_ff[3][2]);
      t[2] = SW'(prod1_ff[0][2]) + SW'(prod1_ff[3][1]) - SW'(prod1_ff[1][3]);
      t[3] = SW'(prod1_ff[0][3]) + SW'(prod1_ff[1][2]) - SW'(prod1_ff[2][1]);
      for (int i = 0; i < 4; i++) begin
         case (op1_ff)
            OP_MUL:   q2_in[i] = t[i] + SW'(prod1_ff[i][0]);
            OP_ROT:   q2_in[i] = t[i];
            OP_SCALE: q2_in[i] = SW'(prod1_ff[i][0]);
            OP_CONJ: begin
               if (i == 0) q2_in[i] = SW'(a1_ff[i]) <<< FRAC;
               else        q2_in[i] = -(SW'(a1_ff[i]) <<< FRAC);
            end
            default:  q2_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         op2_ff <= op1_ff;
         a2_ff  <= a1_ff;
         q2_ff  <= q2_in;
      end
   end

   // ---------------- stage 3 ----------------
   // Products for R = P * conj(A); even slots enter the sum negated.
   always_comb begin
      m3_in[0]  = RPW'(q2_ff[0]) * RPW'(a2_ff[1]);
      m3_in[1]  = RPW'(q2_ff[1]) * RPW'(a2_ff[0]);
      m3_in[2]  = RPW'(q2_ff[2]) * RPW'(a2_ff[3]);
      m3_in[3]  = RPW'(q2_ff[3]) * RPW'(a2_ff[2]);
      m3_in[4]  = RPW'(q2_ff[0]) * RPW'(a2_ff[2]);
      m3_in[5]  = RPW'(q2_ff[2]) * RPW'(a2_ff[0]);
      m3_in[6]  = RPW'(q2_ff[3]) * RPW'(a2_ff[1]);
      m3_in[7]  = RPW'(q2_ff[1]) * RPW'(a2_ff[3]);
      m3_in[8]  = RPW'(q2_ff[0]) * RPW'(a2_ff[3]);
      m3_in[9]  = RPW'(q2_ff[3]) * RPW'(a2_ff[0]);
      m3_in[10] = RPW'(q2_ff[1]) * RPW'(a2_ff[2]);
      m3_in[11] = RPW'(q2_ff[2]) * RPW'(a2_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         op3_ff <= op2_ff;
         q3_ff  <= q2_ff;
         m3_ff  <= m3_in;
      end
   end

   // ---------------- stage 4 ----------------
   // Round half toward +inf: add half an LSB, then arithmetic shift.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rot_sum[k] = RSW'(m3_ff[4*k+1]) + RSW'(m3_ff[4*k+3])
                    - RSW'(m3_ff[4*k])   - RSW'(m3_ff[4*k+2])
                    + (RSW'(1) <<< (ROT_SH - 1));
      end
      for (int i = 0; i < 4; i++) begin
         lin_sum[i] = RSW'(q3_ff[i]) + (RSW'(1) <<< (FRAC - 1));
      end
      if (op3_ff == OP_ROT) begin
         rnd4_in[0] = '0;
         for (int k = 0; k < 3; k++) begin
            rnd4_in[k+1] = RNDW'(rot_sum[k] >>> ROT_SH);
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            rnd4_in[i] = RNDW'(lin_sum[i] >>> FRAC);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         op4_ff  <= op3_ff;
         rnd4_ff <= rnd4_in;
      end
   end

   // ---------------- stage 5 ----------------
   always_comb begin
      logic hit [4];
      rsp5_in.r_w       = clip(rnd4_ff[0], hit[0]);
      rsp5_in.r_x       = clip(rnd4_ff[1], hit[1]);
      rsp5_in.r_y       = clip(rnd4_ff[2], hit[2]);
      rsp5_in.r_z       = clip(rnd4_ff[3], hit[3]);
      rsp5_in.saturated = hit[0] || hit[1] || hit[2] || hit[3];
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         rsp5_ff <= rsp5_in;
      end
   end

   // ---------------- assertions ----------------
   `QALU_ASSERT_NOW(a_ready_chain, clock, reset, rsp_ready, req_ready,
      "input stalled while the output side is draining")
   `QALU_ASSERT_NEXT(a_rot_scalar, clock, reset, v4_ff && en5 && (op4_ff == OP_ROT),
      rsp_item.r_w == '0, "rotate result has nonzero scalar part")
   `QALU_ASSERT_NOW(a_sat_flag, clock, reset, rsp_valid && rsp_item.saturated,
      (rsp_item.r_w == FIX_MAX) || (rsp_item.r_w == FIX_MIN) ||
      (rsp_item.r_x == FIX_MAX) || (rsp_item.r_x == FIX_MIN) ||
      (rsp_item.r_y == FIX_MAX) || (rsp_item.r_y == FIX_MIN) ||
      (rsp_item.r_z == FIX_MAX) || (rsp_item.r_z == FIX_MIN),
      "saturated flag set with no clipped component")
   `QALU_ASSERT_NEXT(a_s2_hold, clock, reset, v2_ff && !en3,
      v2_ff && $stable(q2_ff[0]) && $stable(op2_ff), "stalled item lost in stage 2")

endmodule

`default_nettype wire
